@@ rtl/mfd_pkg.sv @@
// shared types and constants for the motor feedback frame decoder
package mfd_pkg;

    localparam int MOTOR_SLOTS = 5;
    localparam int SLOT_W = 3;
    localparam int SLOT_IDX_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [10:0] ID_FB_FIRST = 11'h201;
    localparam logic [10:0] ID_FB_LAST = 11'h204;
    localparam logic [10:0] ID_FB_BUS1 = 11'h205;
    localparam logic [10:0] ID_CMD = 11'h400;
    localparam logic [SLOT_W-1:0] SLOT_BUS1 = 3'd4;

    localparam logic BUS_FIRST = 1'b0;
    localparam logic BUS_SECOND = 1'b1;

    localparam logic KIND_FEEDBACK = 1'b0;
    localparam logic KIND_MESSAGE = 1'b1;

    localparam logic signed [16:0] TURN_THRESH = 17'sd4096;
    localparam int TURN_SHIFT = 13;

    localparam logic [7:0] STARTUP_FRAMES_RESET = 8'd10;
    localparam logic REG_STARTUP_FRAMES = 1'b0;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [63:0]       payload;
    } mfd_item_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       encoder;
        logic [31:0]       total_angle;
        logic [15:0]       speed;
        logic [15:0]       current;
        logic [7:0]        temperature;
        logic [15:0]       word_a;
        logic [15:0]       word_b;
        logic [15:0]       word_c;
        logic [15:0]       word_d;
    } mfd_result_t;

endpackage

@@ rtl/motor_feedback_frame_decoder.sv @@
// top level: stream ports, configuration register, front, queue and back end
// an accepted item is written into the queue, then popped into the result register when the output is free
// throughput: one item per cycle while the queue is not full; the queue and the result register take up stalls
// the per-slot turn update is a read-modify-write in the back end
// unmapped frames are dropped at the front and give no result
// reset (rst_n low, asynchronous) clears turn counts, previous encoders and the startup
// counter, empties the queue, and sets startup_frames to 10
module motor_feedback_frame_decoder
    import mfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input frames
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // frame_id[10:0], payload[74:11], zero pad
    input  logic         s_tuser,  // bus
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[2:0], encoder[18:3], total_angle[50:19], speed[66:51], current[82:67],
    // temperature[90:83], word_a[106:91], word_b[122:107], word_c[138:123],
    // word_d[154:139], zero pad
    output logic [159:0] m_tdata,
    output logic         m_tuser   // kind
);

    logic [7:0]  startup_frames_reg;
    logic        cfg_write;
    logic        queue_full;
    logic        queue_not_empty;
    logic        push;
    logic        pop;
    mfd_item_t   push_item;
    mfd_item_t   pop_item;
    mfd_result_t result;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_STARTUP_FRAMES);
    assign prdata = (paddr[2] == REG_STARTUP_FRAMES) ? {24'd0, startup_frames_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_frames_reg <= STARTUP_FRAMES_RESET;
        end
        else if (cfg_write)
        begin
            startup_frames_reg <= pwdata[7:0];
        end
    end

    mfd_front u_front (
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .bus        (s_tuser),
        .frame_id   (s_tdata[10:0]),
        .payload    (s_tdata[74:11]),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    mfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    mfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_item      (pop_item),
        .pop             (pop),
        .startup_frames  (startup_frames_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_result      (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = {5'd0, result.word_d, result.word_c, result.word_b, result.word_a,
                      result.temperature, result.current, result.speed,
                      result.total_angle, result.encoder, result.slot};

endmodule

@@ rtl/mfd_front.sv @@
// front end: frame classification and queue push
module mfd_front
    import mfd_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        bus,
    input  logic [10:0] frame_id,
    input  logic [63:0] payload,
    input  logic        queue_full,
    output logic        push,
    output mfd_item_t   push_item
);

    logic              is_cmd;
    logic              is_fb0;
    logic              is_fb1;
    logic [10:0]       id_offset;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic              keep;

    always_comb
    begin
        is_cmd = (bus == BUS_SECOND) && (frame_id == ID_CMD);
        is_fb0 = (bus == BUS_FIRST) && (frame_id >= ID_FB_FIRST) && (frame_id <= ID_FB_LAST);
        is_fb1 = (bus == BUS_SECOND) && (frame_id == ID_FB_BUS1);
        id_offset = frame_id - ID_FB_FIRST;
        slot = is_fb1 ? SLOT_BUS1 : id_offset[SLOT_W-1:0];
        // slots past the configured count are dropped
        slot_ok = ({1'b0, slot} < (SLOT_W + 1)'(MOTOR_SLOTS));
        keep = is_cmd || ((is_fb0 || is_fb1) && slot_ok);

        in_ready = !queue_full;
        push = in_valid && !queue_full && keep;

        push_item.kind = is_cmd ? KIND_MESSAGE : KIND_FEEDBACK;
        push_item.slot = is_cmd ? '0 : slot;
        push_item.payload = payload;
    end

endmodule

@@ rtl/mfd_queue.sv @@
// small queue between the classifier and the decode stage
module mfd_queue
    import mfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  mfd_item_t push_item,
    output logic      full,
    output logic      not_empty,
    input  logic      pop,
    output mfd_item_t pop_item
);

    mfd_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        full = (count_reg == QCNT_W'(QUEUE_DEPTH));
        not_empty = (count_reg != '0);
        pop_item = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");

endmodule

@@ rtl/mfd_back.sv @@
// back end: per-slot turn tracking, field unpacking and result register
module mfd_back
    import mfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_not_empty,
    input  mfd_item_t   queue_item,
    output logic        pop,
    input  logic [7:0]  startup_frames,
    output logic        out_valid,
    input  logic        out_ready,
    output mfd_result_t out_result
);

    logic [15:0] prev_enc_reg [MOTOR_SLOTS];
    logic [31:0] turn_reg [MOTOR_SLOTS];
    logic [7:0]  startup_cnt_reg;
    logic [7:0]  startup_cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    mfd_result_t result_reg;
    mfd_result_t result_next;

    logic [SLOT_IDX_W-1:0] idx;
    logic [15:0]           enc;
    logic [15:0]           prev;
    logic [31:0]           turn;
    logic [31:0]           turn_new;
    logic signed [16:0]    diff;
    logic                  hold;
    logic                  pop_fb;

    always_comb
    begin
        pop = queue_not_empty && (!out_valid_reg || out_ready);
        pop_fb = pop && (queue_item.kind == KIND_FEEDBACK);

        idx = queue_item.slot[SLOT_IDX_W-1:0];
        enc = queue_item.payload[63:48];
        prev = prev_enc_reg[idx];
        turn = turn_reg[idx];
        diff = $signed({1'b0, enc}) - $signed({1'b0, prev});
        hold = (startup_cnt_reg <= startup_frames);

        if (hold)
        begin
            turn_new = '0;
        end
        else if (diff < -TURN_THRESH)
        begin
            turn_new = turn + 32'd1;
        end
        else if (diff > TURN_THRESH)
        begin
            turn_new = turn - 32'd1;
        end
        else
        begin
            turn_new = turn;
        end

        startup_cnt_next = startup_cnt_reg;
        if (pop_fb && hold)
        begin
            startup_cnt_next = startup_cnt_reg + 8'd1;
        end

        result_next = '0;
        result_next.kind = queue_item.kind;
        if (queue_item.kind == KIND_MESSAGE)
        begin
            result_next.word_a = 16'd0 - queue_item.payload[63:48];
            result_next.word_b = queue_item.payload[47:32];
            result_next.word_c = queue_item.payload[31:16];
            result_next.word_d = queue_item.payload[15:0];
        end
        else
        begin
            result_next.slot = queue_item.slot;
            result_next.encoder = enc;
            result_next.total_angle = (turn_new << TURN_SHIFT) + {16'd0, enc};
            result_next.speed = queue_item.payload[47:32];
            result_next.current = queue_item.payload[31:16];
            result_next.temperature = queue_item.payload[15:8];
        end

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        out_valid = out_valid_reg;
        out_result = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_SLOTS; i++)
            begin
                prev_enc_reg[i] <= '0;
                turn_reg[i] <= '0;
            end
            startup_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_fb)
            begin
                prev_enc_reg[idx] <= enc;
                turn_reg[idx] <= turn_new;
            end
            startup_cnt_reg <= startup_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    a_startup_only_on_feedback: assert property (@(posedge clk) disable iff (!rst_n)
        !pop_fb |=> $stable(startup_cnt_reg))
        else $error("startup counter moved without a feedback item");

    a_hold_angle_is_encoder: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_fb && hold) |=> (result_reg.total_angle == {16'd0, result_reg.encoder}))
        else $error("angle not held at encoder during startup");

    a_message_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.kind == KIND_MESSAGE)) |-> (result_reg.slot == '0))
        else $error("message result with nonzero slot");

endmodule
